/* hw/rtl/vsqbs_pkg.sv */
// Package for the vertex-split quadratic B-spline interpolator.
// Holds the tap numbering shared by the stencil mirror and the top level.
// No dependencies.
package vsqbs_pkg;

    // Number of mirrored taps passed down the pipeline (the backward corner is dropped).
    localparam int NUM_TAPS = 8;

    // Tap positions after mirroring, named as if the point lies down and right.
    localparam logic [2:0] TAP_U  = 3'd0;
    localparam logic [2:0] TAP_UR = 3'd1;
    localparam logic [2:0] TAP_L  = 3'd2;
    localparam logic [2:0] TAP_R  = 3'd3;
    localparam logic [2:0] TAP_DL = 3'd4;
    localparam logic [2:0] TAP_D  = 3'd5;
    localparam logic [2:0] TAP_DR = 3'd6;
    localparam logic [2:0] TAP_C  = 3'd7;

endpackage

/* hw/rtl/vsqbs_mirror.sv */
// Stencil mirror and offset decode for the B-spline interpolator.
// Reflects the 3x3 window by the offset signs and forms the doubled magnitudes.
// Depends on vsqbs_pkg for the tap numbering.
module vsqbs_mirror #(
    parameter int PIXEL_BITS = 8,
    parameter int FRAC_BITS  = 8
) (
    input  logic signed [FRAC_BITS-1:0]                          offset_x,
    input  logic signed [FRAC_BITS-1:0]                          offset_y,
    input  logic [PIXEL_BITS-1:0]                                pix_up_left,
    input  logic [PIXEL_BITS-1:0]                                pix_up,
    input  logic [PIXEL_BITS-1:0]                                pix_up_right,
    input  logic [PIXEL_BITS-1:0]                                pix_left,
    input  logic [PIXEL_BITS-1:0]                                pix_centre,
    input  logic [PIXEL_BITS-1:0]                                pix_right,
    input  logic [PIXEL_BITS-1:0]                                pix_down_left,
    input  logic [PIXEL_BITS-1:0]                                pix_down,
    input  logic [PIXEL_BITS-1:0]                                pix_down_right,
    output logic [vsqbs_pkg::NUM_TAPS-1:0][PIXEL_BITS-1:0]       taps,
    output logic [FRAC_BITS:0]                                   t_x,
    output logic [FRAC_BITS:0]                                   a_x,
    output logic [FRAC_BITS:0]                                   t_y,
    output logic [FRAC_BITS:0]                                   a_y
);
    import vsqbs_pkg::*;

    localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;

    logic                  neg_x;
    logic                  neg_y;
    logic [FRAC_BITS-1:0]  raw_x;
    logic [FRAC_BITS-1:0]  raw_y;
    logic [FRAC_BITS-1:0]  mag_x;
    logic [FRAC_BITS-1:0]  mag_y;
    logic [PIXEL_BITS-1:0] fwd_l, fwd_m, fwd_r;
    logic [PIXEL_BITS-1:0] bwd_l, bwd_m, bwd_r;

    // Offset magnitudes; the most negative code gives exactly half a pixel.
    assign raw_x = $unsigned(offset_x);
    assign raw_y = $unsigned(offset_y);
    assign neg_x = raw_x[FRAC_BITS-1];
    assign neg_y = raw_y[FRAC_BITS-1];
    assign mag_x = neg_x ? (~raw_x + 1'b1) : raw_x;
    assign mag_y = neg_y ? (~raw_y + 1'b1) : raw_y;

    // Doubled magnitude t and its complement 1 - t, both in units of 2^-F.
    assign t_x = {mag_x, 1'b0};
    assign t_y = {mag_y, 1'b0};
    assign a_x = ONE - t_x;
    assign a_y = ONE - t_y;

    // Forward row lies on the side the point moves toward.
    assign fwd_l = neg_y ? pix_up_left   : pix_down_left;
    assign fwd_m = neg_y ? pix_up        : pix_down;
    assign fwd_r = neg_y ? pix_up_right  : pix_down_right;
    assign bwd_l = neg_y ? pix_down_left : pix_up_left;
    assign bwd_m = neg_y ? pix_down      : pix_up;
    assign bwd_r = neg_y ? pix_down_right: pix_up_right;

    // Pick columns within each row; the backward-backward corner is never used.
    always_comb
    begin
        taps         = '0;
        taps[TAP_U]  = bwd_m;
        taps[TAP_UR] = neg_x ? bwd_l : bwd_r;
        taps[TAP_L]  = neg_x ? pix_right : pix_left;
        taps[TAP_R]  = neg_x ? pix_left : pix_right;
        taps[TAP_DL] = neg_x ? fwd_r : fwd_l;
        taps[TAP_D]  = fwd_m;
        taps[TAP_DR] = neg_x ? fwd_l : fwd_r;
        taps[TAP_C]  = pix_centre;
    end

endmodule

/* hw/rtl/vsqbs_interpolator.sv */
// Top level of the vertex-split quadratic B-spline interpolator.
// Six-stage pipeline with per-stage valid bits; uses vsqbs_pkg and vsqbs_mirror.
//
// The block takes one item per clock while the output side is not stalled and
// returns one result per item, in order. Each stage holds its item while the
// stage after it is full and stalled, so bubbles are squeezed out and in_ready
// stays high while any stage has room. The stages are: stencil mirror and
// offset decode, axis weight squares, horizontal tap products, split vertical
// products, partial sums, and the final rounding divide by 4*D^2 with
// saturation into the output register. All arithmetic is exact until that
// final divide.
module vsqbs_interpolator #(
    parameter int PIXEL_BITS = 8,
    parameter int FRAC_BITS  = 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [FRAC_BITS-1:0]  offset_x,
    input  logic signed [FRAC_BITS-1:0]  offset_y,
    input  logic [PIXEL_BITS-1:0]        pix_up_left,
    input  logic [PIXEL_BITS-1:0]        pix_up,
    input  logic [PIXEL_BITS-1:0]        pix_up_right,
    input  logic [PIXEL_BITS-1:0]        pix_left,
    input  logic [PIXEL_BITS-1:0]        pix_centre,
    input  logic [PIXEL_BITS-1:0]        pix_right,
    input  logic [PIXEL_BITS-1:0]        pix_down_left,
    input  logic [PIXEL_BITS-1:0]        pix_down,
    input  logic [PIXEL_BITS-1:0]        pix_down_right,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [PIXEL_BITS-1:0]        pixel_out
);
    import vsqbs_pkg::*;

    localparam int NSTG = 6;
    localparam int TW   = FRAC_BITS + 1;                 // t and 1 - t
    localparam int WW   = 2*FRAC_BITS + 2;               // single axis weight
    localparam int SW   = 2*FRAC_BITS + 3;               // sums of weights
    localparam int VW   = 2*FRAC_BITS + 2;               // vertical weight sums
    localparam int BW   = 2*FRAC_BITS + PIXEL_BITS + 3;  // horizontal tap products
    localparam int H    = (BW + 1) / 2;                  // split point of the products
    localparam int PLW  = VW + H;
    localparam int PHW  = VW + BW - H;
    localparam int SUMW = 4*FRAC_BITS + PIXEL_BITS + 5;
    localparam int QSH  = 4*FRAC_BITS + 4;

    localparam logic [SW-1:0]         D_SW    = SW'(1) << (2*FRAC_BITS + 1);
    localparam logic [SUMW-1:0]       ROUND   = SUMW'(1) << (4*FRAC_BITS + 3);
    localparam logic [PIXEL_BITS-1:0] PIX_MAX = '1;

    // Pipeline control.
    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] vld_next;
    logic [NSTG-1:0] adv;

    // Stage 1: mirrored taps and decoded offsets.
    logic [NUM_TAPS-1:0][PIXEL_BITS-1:0] taps_next;
    logic [NUM_TAPS-1:0][PIXEL_BITS-1:0] taps1_reg;
    logic [TW-1:0] tx_next, ax_next, ty_next, ay_next;
    logic [TW-1:0] tx_reg, ax_reg, ty_reg, ay_reg;

    // Stage 2: axis weights.
    logic [NUM_TAPS-1:0][PIXEL_BITS-1:0] taps2_reg;
    logic [WW-1:0] lh_reg, rh_reg, tv_reg, bv_reg;

    // Stage 3: horizontal products and vertical weights.
    logic [SW-1:0] w_lc, w_cr, w_all;
    logic [3:0][BW-1:0] br_next;
    logic [3:0][BW-1:0] br_reg;
    logic [3:0][VW-1:0] vw_next;
    logic [3:0][VW-1:0] vw_reg;
    logic [BW-1:0]      brc_next;
    logic [BW-1:0]      brc3_reg;

    // Stage 4: split vertical products.
    logic [3:0][PLW-1:0] plo_reg;
    logic [3:0][PHW-1:0] phi_reg;
    logic [BW-1:0]       brc4_reg;

    // Stage 5: partial sums.
    logic [SUMW-1:0] pa_next, pb_next;
    logic [SUMW-1:0] pa_reg, pb_reg;

    // Output stage.
    logic [SUMW-1:0]       tot;
    logic [PIXEL_BITS:0]   quo;
    logic [PIXEL_BITS-1:0] pix_next;
    logic [PIXEL_BITS-1:0] pixel_out_reg;

    // A stage advances when it is empty or the stage after it advances.
    always_comb
    begin
        adv[NSTG-1] = !vld_reg[NSTG-1] || out_ready;
        for (int i = NSTG-2; i >= 0; i--)
        begin
            adv[i] = !vld_reg[i] || adv[i+1];
        end
        vld_next = {vld_reg[NSTG-2:0], in_valid};
    end

    assign in_ready  = adv[0];
    assign out_valid = vld_reg[NSTG-1];
    assign pixel_out = pixel_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < NSTG; i++)
            begin
                if (adv[i])
                begin
                    vld_reg[i] <= vld_next[i];
                end
            end
        end
    end

    // Stage 1 logic: mirror the window and decode the offsets.
    vsqbs_mirror #(
        .PIXEL_BITS (PIXEL_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_mirror (
        .offset_x       (offset_x),
        .offset_y       (offset_y),
        .pix_up_left    (pix_up_left),
        .pix_up         (pix_up),
        .pix_up_right   (pix_up_right),
        .pix_left       (pix_left),
        .pix_centre     (pix_centre),
        .pix_right      (pix_right),
        .pix_down_left  (pix_down_left),
        .pix_down       (pix_down),
        .pix_down_right (pix_down_right),
        .taps           (taps_next),
        .t_x            (tx_next),
        .a_x            (ax_next),
        .t_y            (ty_next),
        .a_y            (ay_next)
    );

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            taps1_reg <= taps_next;
            tx_reg    <= tx_next;
            ax_reg    <= ax_next;
            ty_reg    <= ty_next;
            ay_reg    <= ay_next;
        end
    end

    // Stage 2: square t and 1 - t on each axis.
    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            taps2_reg <= taps1_reg;
            lh_reg    <= WW'(ax_reg) * WW'(ax_reg);
            rh_reg    <= WW'(tx_reg) * WW'(tx_reg);
            tv_reg    <= WW'(ay_reg) * WW'(ay_reg);
            bv_reg    <= WW'(ty_reg) * WW'(ty_reg);
        end
    end

    // Stage 3: weight sums and the horizontal products of each row.
    always_comb
    begin
        w_lc  = D_SW - SW'(rh_reg);
        w_cr  = D_SW - SW'(lh_reg);
        w_all = (D_SW << 1) - SW'(rh_reg) - SW'(bv_reg);

        br_next[0] = BW'(w_lc) * BW'(taps2_reg[TAP_U])
                   + BW'(rh_reg) * BW'(taps2_reg[TAP_UR]);
        br_next[1] = BW'(lh_reg) * BW'(taps2_reg[TAP_L])
                   + BW'(w_cr) * BW'(taps2_reg[TAP_R]);
        br_next[2] = BW'(w_lc) * BW'(taps2_reg[TAP_D])
                   + BW'(rh_reg) * BW'(taps2_reg[TAP_DR]);
        br_next[3] = BW'(lh_reg) * BW'(taps2_reg[TAP_DL])
                   + BW'(w_cr) * BW'(taps2_reg[TAP_DR]);
        brc_next   = BW'(w_all) * BW'(taps2_reg[TAP_C])
                   + BW'(rh_reg) * BW'(taps2_reg[TAP_R])
                   + BW'(bv_reg) * BW'(taps2_reg[TAP_D]);

        vw_next[0] = VW'(tv_reg);
        vw_next[1] = VW'(D_SW - SW'(bv_reg));
        vw_next[2] = VW'(D_SW - SW'(tv_reg));
        vw_next[3] = VW'(bv_reg);
    end

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            br_reg   <= br_next;
            vw_reg   <= vw_next;
            brc3_reg <= brc_next;
        end
    end

    // Stage 4: vertical weights times the low and high halves of each row product.
    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            for (int k = 0; k < 4; k++)
            begin
                plo_reg[k] <= PLW'(vw_reg[k]) * PLW'(br_reg[k][H-1:0]);
                phi_reg[k] <= PHW'(vw_reg[k]) * PHW'(br_reg[k][BW-1:H]);
            end
            brc4_reg <= brc3_reg;
        end
    end

    // Stage 5: rebuild row products, add centre term and rounding, sum in two groups.
    always_comb
    begin
        pa_next = (SUMW'(phi_reg[0]) << H) + SUMW'(plo_reg[0])
                + (SUMW'(phi_reg[1]) << H) + SUMW'(plo_reg[1]);
        pb_next = (SUMW'(phi_reg[2]) << H) + SUMW'(plo_reg[2])
                + (SUMW'(phi_reg[3]) << H) + SUMW'(plo_reg[3])
                + (SUMW'(brc4_reg) << (2*FRAC_BITS + 1)) + ROUND;
    end

    always_ff @(posedge clk)
    begin
        if (adv[4])
        begin
            pa_reg <= pa_next;
            pb_reg <= pb_next;
        end
    end

    // Output stage: final add, divide by 4*D^2 and saturate.
    always_comb
    begin
        tot      = pa_reg + pb_reg;
        quo      = tot[SUMW-1:QSH];
        pix_next = quo[PIXEL_BITS] ? PIX_MAX : quo[PIXEL_BITS-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv[5])
        begin
            pixel_out_reg <= pix_next;
        end
    end

    // An accepted item always lands in the first stage.
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> vld_reg[0])
        else $error("accepted item did not enter the first stage");

    // A full stage that cannot advance keeps its item.
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[2] && !adv[2]) |=> vld_reg[2])
        else $error("stalled middle stage dropped its item");

    // A result appears only from a full partial-sum stage.
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(vld_reg[NSTG-1]) |-> $past(vld_reg[NSTG-2]))
        else $error("result appeared without an item behind it");

    // The weights sum to one, so the quotient never exceeds the pixel range.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[NSTG-2] |-> !quo[PIXEL_BITS])
        else $error("interpolated value exceeded the pixel range");

endmodule

/* tb/sv/vsqbs_interpolator_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for vsqbs_interpolator: exact B-spline sample predictor,
// valid/ready driver and monitor, directed and random 3x3 windows.
// Depends only on the RTL of vsqbs_interpolator.
module vsqbs_interpolator_tb;

    localparam int PIX_W = 8;
    localparam int FRAC_W = 8;
    localparam int CLK_PERIOD = 12;
    localparam int RESET_CYCLES = 12;
    localparam int PIPE_LATENCY = 6;
    localparam int HOLD_CYCLES = 300;
    localparam int TIMEOUT_CYCLES = 200000;
    localparam int PHASE_ITEMS = 170;

    localparam logic [127:0] ONE = 128'd1 << FRAC_W;
    localparam logic [127:0] WEIGHT_DEN = 128'd1 << (2 * FRAC_W + 1);
    localparam logic [127:0] PIX_MAX = (128'd1 << PIX_W) - 1;

    // One 3x3 window with its sampling offsets, pixels in row-major order.
    typedef struct packed {
        logic [FRAC_W-1:0] off_x;
        logic [FRAC_W-1:0] off_y;
        logic [8:0][PIX_W-1:0] pix;
    } window_item_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic out_ready = 1'b0;
    logic in_ready;
    logic out_valid;
    logic [PIX_W-1:0] pixel_out;
    window_item_t cur_window = '0;

    window_item_t pending_windows[$];
    logic [PIX_W-1:0] expected_pixels[$];
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit hold_req = 1'b0;
    int error_count = 0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    vsqbs_interpolator #(
        .PIXEL_BITS(PIX_W),
        .FRAC_BITS(FRAC_W)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .offset_x(cur_window.off_x),
        .offset_y(cur_window.off_y),
        .pix_up_left(cur_window.pix[0]),
        .pix_up(cur_window.pix[1]),
        .pix_up_right(cur_window.pix[2]),
        .pix_left(cur_window.pix[3]),
        .pix_centre(cur_window.pix[4]),
        .pix_right(cur_window.pix[5]),
        .pix_down_left(cur_window.pix[6]),
        .pix_down(cur_window.pix[7]),
        .pix_down_right(cur_window.pix[8]),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .pixel_out(pixel_out)
    );

    // T = 2*|offset| as an integer over 2^F; the most negative offset gives T = 2^F.
    function automatic logic [127:0] twice_magnitude(input logic [FRAC_W-1:0] raw);
        logic [127:0] v;
        v = 128'(raw);
        return raw[FRAC_W-1] ? ((ONE - v) << 1) : (v << 1);
    endfunction

    // Quadratic B-spline weights of one axis, exact over 2^(2F+1).
    function automatic void axis_weights(input logic [127:0] t,
                                         output logic [127:0] wl,
                                         output logic [127:0] wc,
                                         output logic [127:0] wr);
        wl = (ONE - t) * (ONE - t);
        wr = t * t;
        wc = WEIGHT_DEN - wl - wr;
    endfunction

    function automatic logic [127:0] tap(input window_item_t w, input int row, input int col);
        return 128'(w.pix[3 * row + col]);
    endfunction

    // Interpolated sample of one window: mirror by offset signs, eight weighted
    // taps summed exactly, then divided by 4*D^2 rounding half up, saturated.
    function automatic logic [PIX_W-1:0] predict_sample(input window_item_t w);
        logic [127:0] lh, ch, rh, tv, mv, bv, acc;
        int fc, fr, bc, brow;
        fc = w.off_x[FRAC_W-1] ? 0 : 2;
        fr = w.off_y[FRAC_W-1] ? 0 : 2;
        bc = 2 - fc;
        brow = 2 - fr;
        axis_weights(twice_magnitude(w.off_x), lh, ch, rh);
        axis_weights(twice_magnitude(w.off_y), tv, mv, bv);
        acc = tv * ((lh + ch) * tap(w, brow, 1) + rh * tap(w, brow, fc))
            + (tv + mv) * (lh * tap(w, 1, bc) + (ch + rh) * tap(w, 1, fc))
            + (mv + bv) * ((lh + ch) * tap(w, fr, 1) + rh * tap(w, fr, fc))
            + bv * (lh * tap(w, fr, bc) + (ch + rh) * tap(w, fr, fc))
            + WEIGHT_DEN * ((lh + ch + tv + mv) * tap(w, 1, 1) + rh * tap(w, 1, fc)
                            + bv * tap(w, fr, 1));
        acc = (acc + (128'd1 << (4 * FRAC_W + 3))) >> (4 * FRAC_W + 4);
        return (acc > PIX_MAX) ? PIX_MAX[PIX_W-1:0] : acc[PIX_W-1:0];
    endfunction

    function automatic window_item_t flat_window(input logic [FRAC_W-1:0] ox,
                                                 input logic [FRAC_W-1:0] oy,
                                                 input logic [PIX_W-1:0] fill);
        window_item_t w;
        w.off_x = ox;
        w.off_y = oy;
        for (int i = 0; i < 9; i++)
        begin
            w.pix[i] = fill;
        end
        return w;
    endfunction

    // Offsets lean toward zero, the half-pixel edges and one step around zero.
    function automatic logic [FRAC_W-1:0] random_offset();
        case ($urandom_range(11))
            0: return '0;
            1: return 8'sd127;
            2: return -8'sd128;
            3: return -8'sd1;
            4: return 8'sd1;
            default: return FRAC_W'($urandom);
        endcase
    endfunction

    function automatic window_item_t random_window();
        window_item_t w;
        w.off_x = random_offset();
        w.off_y = random_offset();
        for (int i = 0; i < 9; i++)
        begin
            case ($urandom_range(9))
                0: w.pix[i] = '0;
                1: w.pix[i] = '1;
                default: w.pix[i] = PIX_W'($urandom);
            endcase
        end
        return w;
    endfunction

    // Sender: offers pending items, holds valid and payload until accepted, and
    // records the expected sample of each accepted item.
    always @(posedge clk or negedge rst_n)
    begin : window_driver
        window_item_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                expected_pixels.push_back(predict_sample(cur_window));
            end
            if (!in_valid || in_ready)
            begin
                if (pending_windows.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    nxt = pending_windows.pop_front();
                    cur_window <= nxt;
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each accepted sample against the oldest expectation and
    // drives out_ready, including one long hold-off on request.
    always @(posedge clk or negedge rst_n)
    begin : sample_monitor
        logic [PIX_W-1:0] want;
        int hold_left;
        bit hold_done;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_left = 0;
            hold_done = 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    $error("pixel_out: expected none, actual %0d", pixel_out);
                    error_count++;
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (pixel_out !== want)
                    begin
                        $error("pixel_out: expected %0d, actual %0d", want, pixel_out);
                        error_count++;
                    end
                end
            end
            if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Stimulus and run control; control variables change on the falling edge.
    initial
    begin : stimulus
        window_item_t w;
        logic [FRAC_W-1:0] hot_off;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Directed windows: flat extremes, offset extremes and sign pairs.
        pending_windows.push_back(flat_window(8'sd0, 8'sd0, 8'd0));
        pending_windows.push_back(flat_window(8'sd0, 8'sd0, 8'd255));
        pending_windows.push_back(flat_window(-8'sd128, -8'sd128, 8'd255));
        pending_windows.push_back(flat_window(8'sd127, 8'sd127, 8'd255));
        w = random_window();
        w.off_x = -8'sd128;
        w.off_y = 8'sd127;
        pending_windows.push_back(w);
        w = random_window();
        w.off_x = 8'sd127;
        w.off_y = -8'sd128;
        pending_windows.push_back(w);
        w = random_window();
        w.off_x = -8'sd1;
        w.off_y = 8'sd1;
        pending_windows.push_back(w);
        w = random_window();
        w.off_x = 8'sd1;
        w.off_y = -8'sd1;
        pending_windows.push_back(w);

        // A single bright pixel at each position, for both mirror directions,
        // so the backward corner is seen to contribute nothing.
        for (int s = 0; s < 2; s++)
        begin
            hot_off = (s == 0) ? -8'sd64 : 8'sd64;
            for (int i = 0; i < 9; i++)
            begin
                w = flat_window(hot_off, hot_off, 8'd0);
                w.pix[i] = 8'd255;
                pending_windows.push_back(w);
            end
        end

        // Phase one: sender idles lightly, receiver idles heavily.
        @(negedge clk);
        send_idle_pct = 38;
        recv_idle_pct = 87;
        for (int i = 0; i < PHASE_ITEMS; i++)
        begin
            pending_windows.push_back(random_window());
        end
        while (pending_windows.size() != 0) @(negedge clk);

        // Phase two: the other way round.
        send_idle_pct = 87;
        recv_idle_pct = 38;
        for (int i = 0; i < PHASE_ITEMS; i++)
        begin
            pending_windows.push_back(random_window());
        end
        while (pending_windows.size() != 0) @(negedge clk);

        // Phase three: no idling, with one long receiver hold-off so the
        // pipeline fills and stalls its input.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int i = 0; i < PHASE_ITEMS; i++)
        begin
            pending_windows.push_back(random_window());
        end
        hold_req = 1'b1;
        while (pending_windows.size() != 0 || in_valid || expected_pixels.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (4 * PIPE_LATENCY) @(negedge clk);

        if (error_count == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin : watchdog
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("CHECK FAILED");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/vsqbs_pkg.sv
hw/rtl/vsqbs_mirror.sv
hw/rtl/vsqbs_interpolator.sv
tb/sv/vsqbs_interpolator_tb.sv
